// ===== design/base64_stream_encoder_top_defines.svh =====
// assertion macros shared by the base64 stream encoder modules
// depends on nothing; included by every file that carries assertions
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property holds at every edge outside reset
`define B64SE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define B64SE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define B64SE_ASSERT(label, clk, rst, prop, msg)
`define B64SE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/b64se_pkg.sv =====
// types, constants and the alphabet lookup of the base64 stream encoder
// depends on nothing
package b64se_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MAX_CHARS   = 4;
  localparam int unsigned CIDX_W      = $clog2(MAX_CHARS);

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] UPPER_BASE = 8'h41;
  localparam logic [7:0] LOWER_BASE = 8'h61;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_text;
  } char_item_t;

  // position of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    PHASE_0,
    PHASE_1,
    PHASE_2
  } phase_t;

  // characters one byte produces, waiting for the serializer
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CIDX_W-1:0]         last_idx;
    logic                      eot;
  } group_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = UPPER_BASE + {2'b00, v};
    end else if (v < 6'd52) begin
      c = LOWER_BASE + ({2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      c = DIGIT_BASE + ({2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

// ===== design/b64se_front.sv =====
// front end: tracks group phase and held bits, turns each byte into a character entry
// depends on b64se_pkg and the assertion macro header
`include "base64_stream_encoder_top_defines.svh"

module b64se_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  b64se_pkg::byte_item_t  byte_data,
  input  b64se_pkg::q_status_t   q_status,
  output logic                   push,
  output b64se_pkg::group_entry_t push_data
);
  import b64se_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] carry;
  logic [3:0] carry_next;
  logic       accept;
  logic [7:0] b;

  assign byte_ready = !q_status.full;
  assign accept     = byte_valid && byte_ready;
  assign push       = accept;
  assign b          = byte_data.in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_0;
      carry <= 4'd0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

  // next phase and held bits
  always_comb begin
    phase_next = PHASE_1;
    carry_next = {2'b00, b[1:0]};
    case (phase)
      PHASE_1: begin
        phase_next = PHASE_2;
        carry_next = b[3:0];
      end
      PHASE_2: begin
        phase_next = PHASE_0;
        carry_next = 4'd0;
      end
      default: begin
      end
    endcase
    if (byte_data.is_last) begin
      phase_next = PHASE_0;
      carry_next = 4'd0;
    end
  end

  // characters for this byte; start-of-group values serve the unused code too
  always_comb begin
    push_data.eot      = byte_data.is_last;
    push_data.chars[0] = b64_char(b[7:2]);
    push_data.chars[1] = b64_char({b[1:0], 4'b0000});
    push_data.chars[2] = PAD_CHAR;
    push_data.chars[3] = PAD_CHAR;
    push_data.last_idx = byte_data.is_last ? CIDX_W'(3) : CIDX_W'(0);
    case (phase)
      PHASE_1: begin
        push_data.chars[0] = b64_char({carry[1:0], b[7:4]});
        push_data.chars[1] = b64_char({b[3:0], 2'b00});
        push_data.last_idx = byte_data.is_last ? CIDX_W'(2) : CIDX_W'(0);
      end
      PHASE_2: begin
        push_data.chars[0] = b64_char({carry, b[7:6]});
        push_data.chars[1] = b64_char(b[5:0]);
        push_data.last_idx = CIDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  `B64SE_ASSERT_NEXT(a_last_restarts_group, clk, rst, accept && byte_data.is_last,
    phase == PHASE_0 && carry == 4'd0, "group not restarted after last byte")
  `B64SE_ASSERT(a_no_push_when_full, clk, rst, !(push && q_status.full),
    "entry pushed into full queue")

endmodule

// ===== design/b64se_queue.sv =====
// short queue of character entries between front end and serializer
// depends on b64se_pkg and the assertion macro header
`include "base64_stream_encoder_top_defines.svh"

module b64se_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  b64se_pkg::group_entry_t push_data,
  input  logic                    pop,
  output b64se_pkg::group_entry_t head,
  output b64se_pkg::q_status_t    q_status
);
  import b64se_pkg::*;

  group_entry_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign head               = mem[rd_ptr];
  assign q_status.full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `B64SE_ASSERT(a_count_bounded, clk, rst, count <= QCNT_W'(QUEUE_DEPTH),
    "queue count beyond depth")
  `B64SE_ASSERT(a_no_pop_when_empty, clk, rst, !(pop && count == '0),
    "pop from empty queue")

endmodule

// ===== design/b64se_back.sv =====
// back end: serializes queue head into output register, one char per cycle unless stalled
// depends on b64se_pkg and the assertion macro header
`include "base64_stream_encoder_top_defines.svh"

module b64se_back (
  input  logic                    clk,
  input  logic                    rst,
  input  b64se_pkg::group_entry_t head,
  input  b64se_pkg::q_status_t    q_status,
  output logic                    pop,
  output logic                    char_valid,
  input  logic                    char_ready,
  output b64se_pkg::char_item_t   char_data
);
  import b64se_pkg::*;

  logic [CIDX_W-1:0] idx;
  logic              load;
  logic              at_end;

  assign load   = q_status.not_empty && (!char_valid || char_ready);
  assign at_end = (idx == head.last_idx);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      char_valid <= 1'b0;
    end else begin
      if (load) begin
        idx        <= at_end ? '0 : idx + 1'b1;
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_data.out_char    <= head.chars[idx];
      char_data.end_of_text <= head.eot && at_end;
    end
  end

  `B64SE_ASSERT(a_idx_in_entry, clk, rst, !q_status.not_empty || idx <= head.last_idx,
    "character index past end of entry")
  `B64SE_ASSERT_NEXT(a_stall_holds, clk, rst, char_valid && !char_ready,
    char_valid && $stable(char_data), "stalled character changed")

endmodule

// ===== design/base64_stream_encoder_top.sv =====
// top level of the base64 stream encoder
// depends on b64se_pkg, b64se_front, b64se_queue and b64se_back
//
// base64 encoder (padded, standard alphabet) over a byte stream. one byte per transfer on the
// byte channel, with is_last set on the final byte of a message; one ascii character per
// transfer on the char channel, with end_of_text set on the final character of the encoded
// message. characters appear as soon as their six bits are known: a group's first and second
// bytes each give one character, its third byte gives two. on the last byte the open group is
// zero-filled and '=' padding brings the message to a multiple of four characters, so a last
// byte gives up to four characters. after the last byte the encoder starts a fresh group.
// rate: the char side moves one character per cycle while char_ready is high, which sets
// throughput: a byte gives one or two characters (three bytes give four) and a last byte up
// to four. the byte side takes a transfer every cycle while the two-entry queue between front
// end and serializer has room. a byte is first written into the queue, and its first
// character then into the output register, ahead of its char transfer. the char output is
// registered, so a stalled character does not stop bytes from being taken until the queue
// fills.
module base64_stream_encoder_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  b64se_pkg::byte_item_t  byte_data,
  output logic                   char_valid,
  input  logic                   char_ready,
  output b64se_pkg::char_item_t  char_data
);
  import b64se_pkg::*;

  // front end to queue
  logic         push;
  group_entry_t push_data;
  // queue to serializer
  logic         pop;
  group_entry_t head;
  q_status_t    q_status;

  // classify the byte by group phase and build its characters
  b64se_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  // decouples byte intake from character output
  b64se_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // one character per cycle into the output register, unless stalled
  b64se_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data)
  );

endmodule
